@@ rtl/lzwd_pkg.sv @@
// lzwd_pkg: shared types and constants for the word-oriented LZSS decompressor.
// Holds operation/status codes, the command passed from front to back,
// and the result item. No dependencies.
`timescale 1ns / 1ps

package lzwd_pkg;

  // history geometry (offset field is 11 bits wide)
  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = 11;
  localparam int CNT_LSB    = 11;

  // operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;

  localparam logic [15:0] FLAG_MSB = 16'h8000;
  localparam logic [4:0]  FLAG_BITS = 5'd16;

  // decoder phase
  typedef enum logic [2:0] {
    PH_ITEM  = 3'b001,
    PH_COUNT = 3'b010,
    PH_RUN   = 3'b100
  } phase_t;

  // what the back end does with a command
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_LIT  = 2'd1,
    K_COPY = 2'd2,
    K_ZERO = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [15:0]          data;
    logic [HIST_AW-1:0]   wa;
    logic [HIST_AW-1:0]   ra;
    logic [1:0]           status;
    logic [15:0]          run_left;
    logic [31:0]          produced;
  } cmd_t;

  typedef struct packed {
    logic        out_valid;
    logic [15:0] out_word;
    logic [1:0]  status;
    logic [15:0] run_left;
    logic [31:0] produced;
  } res_t;

endpackage

@@ rtl/lzwd_fifo.sv @@
// lzwd_fifo: small register-based queue with occupancy count.
// Generic payload vector; no package dependency.
`timescale 1ns / 1ps

module lzwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    rptr;
  logic [AW-1:0]    wptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/lzwd_front.sv @@
// lzwd_front: parses the compressed stream (flags, tokens, counts, ticks)
// and issues one command per transfer. Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    operation,
  input  logic [15:0]   word,
  output lzwd_pkg::cmd_t cmd
);

  lzwd_pkg::phase_t                 phase, phase_next;
  logic [15:0]                      flag_bits, flag_bits_next;
  logic [4:0]                       flag_left, flag_left_next;
  logic [lzwd_pkg::HIST_AW-1:0]     pend_off, pend_off_next;
  logic [15:0]                      pend_cnt, pend_cnt_next;
  logic [lzwd_pkg::HIST_AW-1:0]     wp, wp_next;
  logic [31:0]                      produced, produced_next;
  logic                             emit;
  logic [4:0]                       tok_cnt;

  assign tok_cnt = word[15:lzwd_pkg::CNT_LSB];

  // decode one item against the current state
  always_comb begin
    phase_next     = phase;
    flag_bits_next = flag_bits;
    flag_left_next = flag_left;
    pend_off_next  = pend_off;
    pend_cnt_next  = pend_cnt;
    wp_next        = wp;
    produced_next  = produced;
    emit           = 1'b0;
    cmd.kind       = lzwd_pkg::K_NONE;
    cmd.data       = word;
    cmd.wa         = wp;
    cmd.ra         = wp - pend_off;
    cmd.status     = lzwd_pkg::ST_OK;

    case (operation)
      lzwd_pkg::OP_START: begin
        phase_next     = lzwd_pkg::PH_ITEM;
        flag_bits_next = '0;
        flag_left_next = '0;
        pend_off_next  = '0;
        pend_cnt_next  = '0;
        wp_next        = '0;
        produced_next  = '0;
      end
      lzwd_pkg::OP_WORD: begin
        if (phase == lzwd_pkg::PH_RUN) begin
          cmd.status = lzwd_pkg::ST_BUSY;
        end else if (phase == lzwd_pkg::PH_COUNT) begin
          pend_cnt_next = word;
          phase_next    = (word == '0) ? lzwd_pkg::PH_ITEM : lzwd_pkg::PH_RUN;
        end else if (flag_left == '0) begin
          flag_bits_next = word;
          flag_left_next = lzwd_pkg::FLAG_BITS;
        end else begin
          flag_bits_next = {flag_bits[14:0], 1'b0};
          flag_left_next = flag_left - 1'b1;
          if ((flag_bits & lzwd_pkg::FLAG_MSB) == '0) begin
            // literal
            emit     = 1'b1;
            cmd.kind = lzwd_pkg::K_LIT;
          end else begin
            // token: count in top bits, zero count means an extension word
            pend_off_next = word[lzwd_pkg::HIST_AW-1:0];
            if (tok_cnt == '0) begin
              pend_cnt_next = '0;
              phase_next    = lzwd_pkg::PH_COUNT;
            end else begin
              pend_cnt_next = 16'(tok_cnt);
              phase_next    = lzwd_pkg::PH_RUN;
            end
          end
        end
      end
      lzwd_pkg::OP_TICK: begin
        if (phase == lzwd_pkg::PH_RUN && pend_cnt != '0) begin
          emit          = 1'b1;
          cmd.kind      = (pend_off != '0) ? lzwd_pkg::K_COPY : lzwd_pkg::K_ZERO;
          pend_cnt_next = pend_cnt - 1'b1;
          if (pend_cnt == 16'd1) begin
            phase_next = lzwd_pkg::PH_ITEM;
          end
        end else begin
          cmd.status = lzwd_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    // every emitted word advances the history pointer and, until it saturates, the count
    if (emit) begin
      wp_next = wp + 1'b1;
      if (produced != '1) begin
        produced_next = produced + 1'b1;
      end
    end

    cmd.run_left = pend_cnt_next;
    cmd.produced = produced_next;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lzwd_pkg::PH_ITEM;
      flag_bits <= '0;
      flag_left <= '0;
      pend_off  <= '0;
      pend_cnt  <= '0;
      wp        <= '0;
      produced  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      flag_bits <= flag_bits_next;
      flag_left <= flag_left_next;
      pend_off  <= pend_off_next;
      pend_cnt  <= pend_cnt_next;
      wp        <= wp_next;
      produced  <= produced_next;
    end
  end

endmodule

@@ rtl/lzwd_back.sv @@
// lzwd_back: executes commands against the history memory, forwards the
// word being written for overlapping copies, clears history after reset.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps

module lzwd_back #(
  parameter int OUTQ_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lzwd_pkg::cmd_t                  head,
  input  logic                            head_valid,
  output logic                            head_pop,
  input  logic [$clog2(OUTQ_DEPTH+1)-1:0] outq_count,
  output logic                            res_push,
  output lzwd_pkg::res_t                  res,
  output logic                            clearing
);

  localparam int CW = $clog2(OUTQ_DEPTH+1);

  logic [15:0]                  hist [lzwd_pkg::HIST_DEPTH];
  logic [lzwd_pkg::HIST_AW-1:0] clr_addr;
  lzwd_pkg::cmd_t               s2;
  logic                         s2_valid;
  logic [15:0]                  rdata;
  logic                         fwd_hit;
  logic [15:0]                  fwd_data;
  logic [15:0]                  s2_value;
  logic                         s2_write;

  // take a command only when no clearing sweep runs and the result queue is sure to have room
  assign head_pop = head_valid && !clearing &&
                    ((CW+1)'(outq_count) + (CW+1)'(s2_valid) < (CW+1)'(OUTQ_DEPTH));

  // resolve the word of the command in the data stage
  always_comb begin
    case (s2.kind)
      lzwd_pkg::K_LIT:  s2_value = s2.data;
      lzwd_pkg::K_COPY: s2_value = fwd_hit ? fwd_data : rdata;
      default:          s2_value = '0;
    endcase
  end

  assign s2_write      = s2_valid && (s2.kind != lzwd_pkg::K_NONE);
  assign res_push      = s2_valid;
  assign res.out_valid = (s2.kind != lzwd_pkg::K_NONE);
  assign res.out_word  = s2_value;
  assign res.status    = s2.status;
  assign res.run_left  = s2.run_left;
  assign res.produced  = s2.produced;

  // control: data stage valid and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      s2_valid <= head_pop;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // data stage payload and bypass of the word written at the same edge
  always_ff @(posedge clk) begin
    if (head_pop) begin
      s2       <= head;
      fwd_hit  <= s2_write && (s2.wa == head.ra);
      fwd_data <= s2_value;
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      hist[clr_addr] <= '0;
    end else if (s2_write) begin
      hist[s2.wa] <= s2_value;
    end
    if (head_pop) begin
      rdata <= hist[head.ra];
    end
  end

endmodule

@@ rtl/lz_word_decompress_top.sv @@
// lz_word_decompress_top: LZSS word decompressor, front parser, command
// queue, history back end and result queue. Depends on lzwd_pkg,
// lzwd_front, lzwd_fifo, lzwd_back.
//
// Usage: items enter through a queue-style port (push/full) carrying
// operation and word; every item yields exactly one result, read through a
// queue-style port (empty/pop) as out_valid, out_word, status, run_left and
// produced. A transfer happens when push is high and full low, or pop high
// and empty low.
// Path: each item passes the command queue, the data stage register and the result queue.
// Throughput: one item per cycle while full stays low; the history memory has one
// read and one write port, and a copy that reads the word written in the
// previous cycle is bypassed around the memory.
// Reset: rst (synchronous) clears the parser state and both queues, then a
// sweep zeroes all 2048 history entries, one entry per cycle; full stays high
// during the sweep. A start operation resets the stream but keeps history.
// Stall: when pop is held low, results collect in the result queue and
// commands then in the command queue; full rises once both are full.
`timescale 1ns / 1ps

module lz_word_decompress_top #(
  parameter int CMDQ_DEPTH = 2,
  parameter int OUTQ_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [15:0] word,
  output logic        empty,
  input  logic        pop,
  output logic        out_valid,
  output logic [15:0] out_word,
  output logic [1:0]  status,
  output logic [15:0] run_left,
  output logic [31:0] produced
);

  lzwd_pkg::cmd_t                  cmd_in;
  lzwd_pkg::cmd_t                  cmd_head;
  logic                            cmdq_full;
  logic                            cmdq_empty;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cmdq_count;
  logic                            cmd_pop;
  logic                            accept;
  lzwd_pkg::res_t                  res_in;
  lzwd_pkg::res_t                  res_out;
  logic                            res_push;
  logic                            outq_full;
  logic [$clog2(OUTQ_DEPTH+1)-1:0] outq_count;
  logic                            clearing;

  assign full   = cmdq_full || clearing;
  assign accept = push && !full;

  // stream parser
  lzwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .word      (word),
    .cmd       (cmd_in)
  );

  // command queue between parser and history back end
  lzwd_fifo #(
    .WIDTH ($bits(lzwd_pkg::cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .full  (cmdq_full),
    .empty (cmdq_empty),
    .count (cmdq_count)
  );

  // history memory and word resolution
  lzwd_back #(
    .OUTQ_DEPTH (OUTQ_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (cmd_head),
    .head_valid (!cmdq_empty && (cmdq_count != '0)),
    .head_pop   (cmd_pop),
    .outq_count (outq_count),
    .res_push   (res_push),
    .res        (res_in),
    .clearing   (clearing)
  );

  // result queue
  lzwd_fifo #(
    .WIDTH ($bits(lzwd_pkg::res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .full  (outq_full),
    .empty (empty),
    .count (outq_count)
  );

  assign out_valid = res_out.out_valid;
  assign out_word  = res_out.out_word;
  assign status    = res_out.status;
  assign run_left  = res_out.run_left;
  assign produced  = res_out.produced;

endmodule
